[hdl/elsl_pkg.sv]
package elsl_pkg;

  // defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int NUM_PORTS_DEF   = 8;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 3;
  localparam int STAMP_W = 32;
  localparam int AGE_W   = 16;
  localparam int MASK_W  = 8;
  localparam int LEN_W   = 16;

  localparam logic [LEN_W-1:0]  MIN_FRAME_LEN = 16'd12;
  localparam logic [MAC_W-1:0]  BCAST_MAC     = 48'hffff_ffff_ffff;
  localparam logic [AGE_W-1:0]  AGE_LIMIT_RST = 16'd60;
  localparam logic [MASK_W-1:0] PORT_MASK_RST = 8'hff;

  // command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // configuration register indexes
  localparam logic CFG_AGE_LIMIT = 1'b0;
  localparam logic CFG_PORT_MASK = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [MAC_W-1:0]   mac;
    logic [PORT_W-1:0]  port;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRC,
    ST_LEARN,
    ST_DST,
    ST_DONE
  } state_t;

  // output bits that correspond to existing ports
  function automatic logic [MASK_W-1:0] port_bits(input int n);
    logic [MASK_W-1:0] b;
    for (int i = 0; i < MASK_W; i++) begin
      b[i] = (i < n);
    end
    return b;
  endfunction

endpackage

[hdl/ethernet_learning_switch_lookup_core.sv]
// Frame item: source table scan, learn step, destination table scan, then a result strobe;
// one entry per cycle through the single table read port. Broadcast skips the destination scan.
// Short frame: no scans, result with an empty port mask. Tick: no result. One item at a time.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low): registers to defaults, then a clearing pass with busy
// high while every table entry is invalidated.
module ethernet_learning_switch_lookup_core #(
  parameter int TABLE_DEPTH = elsl_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_PORTS   = elsl_pkg::NUM_PORTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_cmd,
  input  logic [elsl_pkg::PORT_W-1:0] in_src_port,
  input  logic [elsl_pkg::LEN_W-1:0]  in_frame_len,
  input  logic [elsl_pkg::MAC_W-1:0]  in_dest_mac,
  input  logic [elsl_pkg::MAC_W-1:0]  in_src_mac,
  // result channel
  output logic                      out_valid,
  output logic [elsl_pkg::MASK_W-1:0] out_port_mask,
  output logic                      out_flooded,
  output logic                      out_learned,
  output logic                      out_table_full,
  // configuration
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [elsl_pkg::AGE_W-1:0]  cfg_wdata
);
  import elsl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0]     DEPTH_C    = CW'(TABLE_DEPTH);
  localparam logic [MASK_W-1:0] PORT_BITS  = port_bits(NUM_PORTS);

  // ---------------------------------------------------------------------------
  // State and registers
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  // scan counter: issues one table read per cycle; pend tracks the read in flight
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;

  logic [STAMP_W-1:0] now_r, now_nxt;
  logic [AGE_W-1:0]   age_limit_r;
  logic [MASK_W-1:0]  act_mask_r;

  // latched frame header
  logic [PORT_W-1:0] sport_r, sport_nxt;
  logic [MAC_W-1:0]  dmac_r, dmac_nxt;
  logic [MAC_W-1:0]  smac_r, smac_nxt;
  logic              drop_r, drop_nxt;

  // source scan results
  logic              hit_r, hit_nxt;
  logic [AW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [PORT_W-1:0] hit_port_r, hit_port_nxt;
  logic              free_r, free_nxt;
  logic [AW-1:0]     free_idx_r, free_idx_nxt;
  logic              learned_r, learned_nxt;
  logic              full_r, full_nxt;

  // destination scan results
  logic              dhit_r, dhit_nxt;
  logic [PORT_W-1:0] dport_r, dport_nxt;

  // result registers
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;
  logic              out_flooded_r, out_flooded_nxt;
  logic              out_learned_r, out_learned_nxt;
  logic              out_full_r, out_full_nxt;

  // table port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, rd_ent;

  logic               accept;
  logic [STAMP_W-1:0] ent_age;
  logic               ent_live;
  logic [MASK_W-1:0]  src_bit;

  // ---------------------------------------------------------------------------
  // Entry table
  // ---------------------------------------------------------------------------
  elsl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd_ent)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // entry read back this cycle: live if valid and not older than the age limit
  assign ent_age  = now_r - rd_ent.stamp;
  assign ent_live = rd_ent.valid && (ent_age <= {{(STAMP_W-AGE_W){1'b0}}, age_limit_r});
  assign src_bit  = MASK_W'(1) << sport_r;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == DEPTH_C) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_cmd == CMD_FRAME) begin
          state_nxt = (in_frame_len < MIN_FRAME_LEN) ? ST_DONE : ST_SRC;
        end
      end
      ST_SRC: begin
        if (cnt_r == DEPTH_C && !pend_r) state_nxt = ST_LEARN;
      end
      ST_LEARN: begin
        state_nxt = (dmac_r == BCAST_MAC) ? ST_DONE : ST_DST;
      end
      ST_DST: begin
        if (cnt_r == DEPTH_C && !pend_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and table control
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_nxt         = cnt_r;
    pend_nxt        = 1'b0;
    pend_idx_nxt    = pend_idx_r;
    now_nxt         = now_r;
    sport_nxt       = sport_r;
    dmac_nxt        = dmac_r;
    smac_nxt        = smac_r;
    drop_nxt        = drop_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_port_nxt    = hit_port_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    learned_nxt     = learned_r;
    full_nxt        = full_r;
    dhit_nxt        = dhit_r;
    dport_nxt       = dport_r;
    out_valid_nxt   = 1'b0;
    out_mask_nxt    = out_mask_r;
    out_flooded_nxt = out_flooded_r;
    out_learned_nxt = out_learned_r;
    out_full_nxt    = out_full_r;
    mem_we          = 1'b0;
    mem_waddr       = cnt_r[AW-1:0];
    mem_wdata       = rd_ent;
    mem_re          = 1'b0;
    mem_raddr       = cnt_r[AW-1:0];

    case (state_r)
      ST_CLEAR: begin
        // sweep the table, one entry a cycle, invalidating each
        if (cnt_r != DEPTH_C) begin
          mem_we          = 1'b1;
          mem_waddr       = cnt_r[AW-1:0];
          mem_wdata       = '0;
          cnt_nxt         = cnt_r + CW'(1);
        end
      end

      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          if (in_cmd == CMD_TICK) begin
            now_nxt = now_r + STAMP_W'(1);
          end else begin
            sport_nxt = in_src_port;
            dmac_nxt  = in_dest_mac;
            smac_nxt  = in_src_mac;
            drop_nxt  = (in_frame_len < MIN_FRAME_LEN);
            hit_nxt   = 1'b0;
            free_nxt  = 1'b0;
            dhit_nxt  = 1'b0;
            learned_nxt = 1'b0;
            full_nxt    = 1'b0;
          end
        end
      end

      ST_SRC: begin
        if (cnt_r != DEPTH_C) begin
          mem_re       = 1'b1;
          mem_raddr    = cnt_r[AW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[AW-1:0];
          cnt_nxt      = cnt_r + CW'(1);
        end
        if (pend_r) begin
          if (ent_live) begin
            if (!hit_r && rd_ent.mac == smac_r) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = pend_idx_r;
              hit_port_nxt = rd_ent.port;
            end
          end else begin
            // stale entry: purge it; it counts as free
            if (rd_ent.valid) begin
              mem_we          = 1'b1;
              mem_waddr       = pend_idx_r;
              mem_wdata       = rd_ent;
              mem_wdata.valid = 1'b0;
            end
            if (!free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = pend_idx_r;
            end
          end
        end
      end

      ST_LEARN: begin
        cnt_nxt         = '0;
        mem_wdata.valid = 1'b1;
        mem_wdata.mac   = smac_r;
        mem_wdata.port  = sport_r;
        mem_wdata.stamp = now_r;
        if (hit_r) begin
          // refresh, moving the entry if the port changed
          mem_we      = 1'b1;
          mem_waddr   = hit_idx_r;
          learned_nxt = (hit_port_r != sport_r);
        end else if (free_r) begin
          mem_we      = 1'b1;
          mem_waddr   = free_idx_r;
          learned_nxt = 1'b1;
        end else begin
          full_nxt = 1'b1;
        end
      end

      ST_DST: begin
        if (cnt_r != DEPTH_C) begin
          mem_re       = 1'b1;
          mem_raddr    = cnt_r[AW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[AW-1:0];
          cnt_nxt      = cnt_r + CW'(1);
        end
        if (pend_r && !dhit_r && ent_live && rd_ent.mac == dmac_r) begin
          dhit_nxt  = 1'b1;
          dport_nxt = rd_ent.port;
        end
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        if (drop_r) begin
          out_mask_nxt    = '0;
          out_flooded_nxt = 1'b0;
          out_learned_nxt = 1'b0;
          out_full_nxt    = 1'b0;
        end else begin
          if (dhit_r) begin
            // known destination; filtered when it sits on the arrival port
            out_mask_nxt = (MASK_W'(1) << dport_r) & ~src_bit & act_mask_r & PORT_BITS;
          end else begin
            out_mask_nxt = ~src_bit & act_mask_r & PORT_BITS;
          end
          out_flooded_nxt = !dhit_r;
          out_learned_nxt = learned_r;
          out_full_nxt    = full_r;
        end
      end

      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      now_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      dhit_r      <= 1'b0;
      learned_r   <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      now_r       <= now_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      dhit_r      <= dhit_nxt;
      learned_r   <= learned_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    pend_idx_r    <= pend_idx_nxt;
    sport_r       <= sport_nxt;
    dmac_r        <= dmac_nxt;
    smac_r        <= smac_nxt;
    drop_r        <= drop_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_port_r    <= hit_port_nxt;
    free_idx_r    <= free_idx_nxt;
    dport_r       <= dport_nxt;
    out_mask_r    <= out_mask_nxt;
    out_flooded_r <= out_flooded_nxt;
    out_learned_r <= out_learned_nxt;
    out_full_r    <= out_full_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= AGE_LIMIT_RST;
      act_mask_r  <= PORT_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AGE_LIMIT: age_limit_r <= cfg_wdata;
        CFG_PORT_MASK: act_mask_r  <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_port_mask  = out_mask_r;
  assign out_flooded    = out_flooded_r;
  assign out_learned    = out_learned_r;
  assign out_table_full = out_full_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // one item gives at most one strobe
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a frame is never sent back to its arrival port
  a_no_reflect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_port_mask[sport_r])
    else $error("frame forwarded to its own arrival port");

  // learning either happened or was skipped for lack of room, never both
  a_learn_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_learned && out_table_full))
    else $error("learned and table_full both set");

  // table writes only come from clearing, purging or learning
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_SRC || state_r == ST_LEARN))
    else $error("table written outside clear, source scan or learn");
`endif

endmodule

[hdl/elsl_table.sv]
module elsl_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  elsl_pkg::entry_t    wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output elsl_pkg::entry_t    rd_data
);
  import elsl_pkg::*;

  entry_t mem [DEPTH];

  // single write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
